@@ rtl/pcs_pkg.sv @@
// Shared constants, register codes and the square-root table for the power curve shaper.
`default_nettype none
package pcs_pkg;

  localparam int SAMPLE_FRAC_BITS = 15;
  localparam int SAMPLE_W         = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int ROOT_STEPS       = 24;
  localparam int DERIVE_STEPS     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER = 2'd1;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_AXIS  = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;

  // k = 2.0 in Q8.24
  localparam logic [31:0] K_RESET = 32'h0200_0000;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  function automatic logic [63:0] isqrt64(input logic [63:0] op_in);
    logic [63:0] op;
    logic [63:0] res;
    logic [63:0] bitv;
    op   = op_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (op >= res + bitv) begin
        op  = op - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // entry i holds 2^(2^-i) in Q1.31, built by the floor square-root chain
  function automatic logic [ROOT_STEPS:1][31:0] root_table();
    logic [ROOT_STEPS:1][31:0] tab;
    logic [63:0] c;
    c = 64'd1 << 32;
    for (int i = 1; i <= ROOT_STEPS; i++) begin
      c = isqrt64(c << 31);
      tab[i] = c[31:0];
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pcs_if.sv @@
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none
interface pcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcs_pkg::SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface pcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcs_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

@@ rtl/power_curve_shaper.sv @@
// An input transfer's result reaches the output register through the fold, normalize, squaring, log, multiply,
// split, exp2, shift and output stages. Throughput: one sample per cycle while not stalled by the output or by the
// exponent unit; 24 squaring stages (log2) and 24 multiply stages (exp2). A power_log2 write runs the exponent unit;
// input ready is low meanwhile. Stalls freeze the whole pipeline; valid bits travel with each stage.
// Reset: pipeline empty, symmetry none, exponent k = 2.0.
`default_nettype none
module power_curve_shaper #(
  parameter int SAMPLE_FRAC_BITS = pcs_pkg::SAMPLE_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pcs_in_if.sink                         in_i,
  pcs_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int F    = SAMPLE_FRAC_BITS;
  localparam int XW   = F + 1;
  localparam int LIW  = $clog2(F + 1);
  localparam int LW   = 24 + LIW;
  localparam int PW   = LW + 32;
  localparam int EW   = PW - 24;
  localparam int NR   = pcs_pkg::ROOT_STEPS;
  localparam int S_SQ    = 2;
  localparam int S_LOG   = S_SQ + NR;
  localparam int S_MUL   = S_LOG + 1;
  localparam int S_SPLIT = S_MUL + 1;
  localparam int S_EXP   = S_SPLIT + 1;
  localparam int S_SHIFT = S_EXP + NR;
  localparam int S_OUT   = S_SHIFT + 1;
  localparam int NST     = S_OUT + 1;

  localparam logic [XW-1:0] ONE  = XW'(1) << F;
  localparam logic [XW-1:0] HALF = ONE >> 1;
  localparam logic [NR:1][31:0] ROOT = pcs_pkg::root_table();

  // ---------------- exponent unit ----------------
  logic [1:0]  mode_q;
  logic [31:0] k_q;
  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [31:0] dacc_q, dacc_d;
  logic [11:0] dfp_q;
  logic [3:0]  dsh_q;
  logic [63:0] dprod;
  logic [32:0] drnd, dsum;
  logic [31:0] dk;
  logic signed [4:0] ip;

  always_comb begin
    ip     = 5'(signed'(cfg_data_i[15:12]));
    dprod  = 64'(dacc_q) * 64'(ROOT[5'(cnt_q) + 5'd1]);
    dacc_d = dfp_q[4'd11 - cnt_q] ? dprod[62:31] : dacc_q;
    drnd   = (dsh_q == 4'd0) ? 33'd0 : (33'd1 << (dsh_q - 4'd1));
    dsum   = {1'b0, dacc_q} + drnd;
    dk     = 32'(dsum >> dsh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pcs_pkg::MODE_NONE;
      k_q    <= pcs_pkg::K_RESET;
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
      dacc_q <= pcs_pkg::ONE_Q31;
      dfp_q  <= 12'd0;
      dsh_q  <= 4'd0;
    end else begin
      if (cfg_we_i && cfg_idx_i == pcs_pkg::REG_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end
      if (cfg_we_i && cfg_idx_i == pcs_pkg::REG_POWER) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
        dacc_q <= pcs_pkg::ONE_Q31;
        dfp_q  <= cfg_data_i[11:0];
        dsh_q  <= 4'(5'sd7 - ip);
      end else if (busy_q) begin
        if (cnt_q == 4'(pcs_pkg::DERIVE_STEPS)) begin
          k_q    <= dk;
          busy_q <= 1'b0;
        end else begin
          dacc_q <= dacc_d;
          cnt_q  <= cnt_q + 4'd1;
        end
      end
    end
  end

  // ---------------- sample pipeline ----------------
  logic en;
  logic sb_v_q    [NST];
  logic [1:0] sb_mode_q [NST];
  logic sb_neg_q  [NST];
  logic sb_zero_q [NST];

  assign en         = !sb_v_q[S_OUT] || out_o.ready;
  assign in_i.ready = en && !busy_q;

  // stage 0: clamp and fold
  logic [24:0]   xw;
  logic [XW-1:0] xc, m_d, m_q;
  logic [XW:0]   two_x, one2, diff;
  logic          neg_d, sym;

  always_comb begin
    xw    = 25'(in_i.sample_in);
    xc    = (xw > 25'(ONE)) ? ONE : xw[XW-1:0];
    two_x = {xc, 1'b0};
    one2  = {1'b0, ONE};
    neg_d = two_x < one2;
    diff  = neg_d ? (one2 - two_x) : (two_x - one2);
    sym   = (mode_q == pcs_pkg::MODE_AXIS) || (mode_q == pcs_pkg::MODE_POINT);
    m_d   = sym ? diff[XW-1:0] : xc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q[0] <= 1'b0;
    end else if (en) begin
      sb_v_q[0] <= in_i.valid && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q          <= m_d;
      sb_mode_q[0] <= mode_q;
      sb_neg_q[0]  <= neg_d;
      sb_zero_q[0] <= 1'b0;
    end
  end

  // stage 1: normalize to a Q1.31 mantissa
  logic [31:0]    sq_mant_q [NR+1];
  logic [23:0]    sq_frac_q [NR+1];
  logic [LIW-1:0] sq_lint_q [NR+1];
  logic [LIW-1:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (m_q[i]) lead = LIW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_mant_q[0] <= 32'(m_q) << (5'd31 - 5'(lead));
      sq_frac_q[0] <= 24'd0;
      sq_lint_q[0] <= LIW'(F) - lead;
    end
  end

  // log2 fraction bits by repeated squaring, one bit per stage
  for (genvar j = 0; j < NR; j++) begin : g_sq
    logic [63:0] sq;
    logic        b;
    assign sq = 64'(sq_mant_q[j]) * 64'(sq_mant_q[j]);
    assign b  = sq[63];
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_mant_q[j+1] <= b ? sq[63:32] : sq[62:31];
        sq_frac_q[j+1] <= {sq_frac_q[j][22:0], b};
        sq_lint_q[j+1] <= sq_lint_q[j];
      end
    end
  end

  // L = -log2 m, then E = L * k rounded to Q.24
  logic [LW-1:0] l_q;
  logic [PW-1:0] lk;
  logic [EW-1:0] e_q;
  assign lk = PW'(l_q) * PW'(k_q) + PW'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q <= (LW'(sq_lint_q[NR]) << 24) - LW'(sq_frac_q[NR]);
      e_q <= lk[PW-1:24];
    end
  end

  // split E into shift n and exp2 fraction g
  logic [31:0]    ex_acc_q [NR+1];
  logic [23:0]    ex_g_q   [NR+1];
  logic [LIW-1:0] ex_n_q   [NR+1];
  logic           ex_two_q [NR+1];
  logic           n_big;
  logic [24:0]    g_full;

  assign n_big  = e_q[EW-1:24] > (EW-24)'(F);
  assign g_full = 25'h100_0000 - {1'b0, e_q[23:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_acc_q[0] <= pcs_pkg::ONE_Q31;
      ex_g_q[0]   <= g_full[23:0];
      ex_n_q[0]   <= e_q[24 +: LIW];
      ex_two_q[0] <= e_q[23:0] == 24'd0;
    end
  end

  // exp2 of g as a product of root factors, one factor per stage
  for (genvar i = 0; i < NR; i++) begin : g_ex
    logic [63:0] pr;
    assign pr = 64'(ex_acc_q[i]) * 64'(ROOT[i+1]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_acc_q[i+1] <= ex_g_q[i][NR-1-i] ? pr[62:31] : ex_acc_q[i];
        ex_g_q[i+1]   <= ex_g_q[i];
        ex_n_q[i+1]   <= ex_n_q[i];
        ex_two_q[i+1] <= ex_two_q[i];
      end
    end
  end

  // shift to Q1.F with rounding, limit to one
  logic [33:0]   accf, rsum, ysh;
  logic [5:0]    sft;
  logic [XW-1:0] pw_d, pw_q;

  always_comb begin
    accf = ex_two_q[NR] ? (34'd1 << 32) : 34'(ex_acc_q[NR]);
    sft  = 6'(32 - F) + 6'(ex_n_q[NR]);
    rsum = accf + (34'd1 << (sft - 6'd1));
    ysh  = rsum >> sft;
    if (sb_zero_q[S_SHIFT-1]) begin
      pw_d = '0;
    end else begin
      pw_d = (ysh > 34'(ONE)) ? ONE : ysh[XW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= pw_d;
    end
  end

  // point symmetry and output register
  logic [XW:0]   hsum;
  logic [XW-1:0] hh, yp, y_d, y_q;

  always_comb begin
    hsum = {1'b0, pw_q} + (XW+1)'(1);
    hh   = hsum[XW:1];
    yp   = sb_neg_q[S_OUT-1] ? (HALF - hh) : (HALF + hh);
    y_d  = (sb_mode_q[S_OUT-1] == pcs_pkg::MODE_POINT) ? yp : pw_q;
    if (y_d > ONE) y_d = ONE;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q <= y_d;
    end
  end

  // sideband per stage
  for (genvar s = 1; s < NST; s++) begin : g_sb
    logic zero_d;
    if (s == 1) begin : g_z1
      assign zero_d = m_q == '0;
    end else if (s == S_SPLIT) begin : g_zs
      assign zero_d = sb_zero_q[s-1] | n_big;
    end else begin : g_zc
      assign zero_d = sb_zero_q[s-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_v_q[s] <= 1'b0;
      end else if (en) begin
        sb_v_q[s] <= sb_v_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sb_mode_q[s] <= sb_mode_q[s-1];
        sb_neg_q[s]  <= sb_neg_q[s-1];
        sb_zero_q[s] <= zero_d;
      end
    end
  end

  assign out_o.valid      = sb_v_q[S_OUT];
  assign out_o.sample_out = pcs_pkg::SAMPLE_W'(y_q);

  // ---------------- checks ----------------
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_i.ready) else $error("input taken while exponent unit busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= 4'(pcs_pkg::DERIVE_STEPS))) else $error("exponent step count overrun");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> sb_v_q[0]) else $error("accepted sample not in first stage");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_v_q[S_OUT] |-> (y_q <= ONE)) else $error("result above one");

endmodule
`default_nettype wire

@@ tb/power_curve_shaper_tb.sv @@
// Self-checking testbench for the power curve shaper: directed and random samples.
`timescale 1ns / 1ps
module power_curve_shaper_tb;

  localparam int FRAC = pcs_pkg::SAMPLE_FRAC_BITS;
  localparam int DRAIN_CYCLES = 70;

  // Bit-exact expected-sample tracker: holds mode, exponent and pending outputs.
  class curve_board;
    logic [1:0]  mode;
    longint unsigned k_q24;
    logic [15:0] pending[$];
    int          errors;

    function new();
      mode   = pcs_pkg::MODE_NONE;
      k_q24  = 64'd1 << 25;
      errors = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // 2^(g/2^24) in Q1.31
    function longint unsigned pow2_frac(longint unsigned g);
      longint unsigned acc, c;
      acc = 64'd1 << 31;
      c   = 64'd1 << 32;
      if (g >= (64'd1 << 24)) return 64'd1 << 32;
      for (int i = 1; i <= 24; i++) begin
        c = floor_sqrt(c << 31);
        if ((g >> (24 - i)) & 1) acc = (acc * c) >> 31;
      end
      return acc;
    endfunction

    function longint unsigned minus_log2(longint unsigned m);
      int e;
      longint unsigned mant, fr;
      e  = 0;
      fr = 0;
      while (e < 40 && (m >> (e + 1)) != 0) e++;
      mant = m << (31 - e);
      for (int i = 0; i < 24; i++) begin
        mant = (mant * mant) >> 31;
        fr = fr << 1;
        if (mant >= (64'd1 << 32)) begin
          fr = fr | 1;
          mant = mant >> 1;
        end
      end
      return (longint'(FRAC - e) << 24) - fr;
    endfunction

    function longint unsigned raise(longint unsigned m);
      longint unsigned e, n, g, acc, s, y;
      if (m == 0) return 0;
      e = (minus_log2(m) * k_q24 + (64'd1 << 23)) >> 24;
      n = e >> 24;
      if (n > 32) return 0;
      g = (64'd1 << 24) - (e & 64'hFF_FFFF);
      acc = pow2_frac(g);
      s = 32 - FRAC + n;
      if (s > 32) return 0;
      y = (acc + (64'd1 << (s - 1))) >> s;
      return (y > (64'd1 << FRAC)) ? (64'd1 << FRAC) : y;
    endfunction

    function void write_reg(logic [pcs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      int ip, fp, sh;
      longint unsigned acc;
      if (idx == pcs_pkg::REG_MODE) begin
        mode = val[1:0];
      end else if (idx == pcs_pkg::REG_POWER) begin
        ip  = $signed(val) >>> 12;
        fp  = $signed(val) - ip * 4096;
        acc = pow2_frac(longint'(fp) << 12);
        sh  = 7 - ip;
        k_q24 = (sh == 0) ? acc : (acc + (64'd1 << (sh - 1))) >> sh;
      end
    endfunction

    function void note_sample(logic [15:0] raw);
      longint unsigned one, x, m, pw, h, y;
      bit neg;
      one = 64'd1 << FRAC;
      x = raw;
      if (x > one) x = one;
      if (mode == pcs_pkg::MODE_AXIS || mode == pcs_pkg::MODE_POINT) begin
        neg = (2 * x) < one;
        m  = neg ? one - 2 * x : 2 * x - one;
        pw = raise(m);
        if (mode == pcs_pkg::MODE_AXIS) begin
          y = pw;
        end else begin
          h = (pw + 1) >> 1;
          y = neg ? (one >> 1) - h : (one >> 1) + h;
        end
      end else begin
        y = raise(x);
      end
      if (y > one) y = one;
      pending.push_back(y[15:0]);
    endfunction

    function void check_sample(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        $error("sample_out: unexpected transfer, actual %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [pcs_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  bit   quiet = 1'b0;
  int   stall_left = 0;
  curve_board board = new();

  pcs_in_if  in_if();
  pcs_out_if out_if();

  power_curve_shaper u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
  end

  // transfers are observed with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) board.note_sample(in_if.sample_in);
    if (rst_ni && out_if.valid && out_if.ready) board.check_sample(out_if.sample_out);
  end

  // result-side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_sample(logic [15:0] x);
    if (!quiet && $urandom_range(0, 15) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample_in <= x;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [pcs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'($urandom_range(32769, 65535));
    if (r == 1) return 16'(32768);
    if (r == 2) return 16'($urandom_range(16380, 16388));
    return 16'($urandom_range(0, 32768));
  endfunction

  logic [15:0] powers[9] = '{16'h8000, 16'h7FFF, 16'h1000, 16'h0000, 16'hF000,
                             16'h2800, 16'hE000, 16'h0800, 16'h5000};

  initial begin
    logic [15:0] dir[$];
    logic [15:0] pw;
    dir = '{16'd0, 16'd1, 16'd2, 16'd16383, 16'd16384, 16'd16385, 16'd32767,
            16'd32768, 16'd32769, 16'd65535, 16'h5555, 16'hAAAA, 16'd8192};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset exponent first, then unknown register indexes
    foreach (dir[i]) send_sample(dir[i]);
    drain();
    write_cfg(2'd2, 16'hFFFF);
    write_cfg(2'd3, 16'h1234);
    for (int md = 0; md < 4; md++) begin
      write_cfg(pcs_pkg::REG_MODE, 16'(md));
      write_cfg(pcs_pkg::REG_POWER, powers[md]);
      foreach (dir[i]) send_sample(dir[i]);
      drain();
    end
    for (int ph = 0; ph < 9; ph++) begin
      pw = (ph < 5) ? powers[ph] : 16'($urandom_range(0, 65535));
      write_cfg(pcs_pkg::REG_MODE, 16'(ph % 4));
      write_cfg(pcs_pkg::REG_POWER, pw);
      if (ph == 8) quiet = 1'b1;
      for (int n = 0; n < 140; n++) begin
        send_sample(rand_sample());
        if (ph == 3 && n == 70) drain();
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
